// File: hdl/frp_pkg.sv
package frp_pkg;

    localparam int MAX_FRAME_DEFAULT = 32;

    localparam logic [1:0] REQ_ARM  = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_HDR_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_BAD_HEAD     = 3'd2;
    localparam logic [2:0] ST_SHORT        = 3'd3;
    localparam logic [2:0] ST_BAD_END      = 3'd4;
    localparam logic [2:0] ST_BODY_TIMEOUT = 3'd5;
    localparam logic [2:0] ST_TOO_LONG     = 3'd6;

    localparam logic [1:0] CFG_HEAD_MARKER  = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_BYTE_TIMEOUT = 2'd2;

    localparam logic [7:0]  HEAD_MARKER_RESET  = 8'd170;
    localparam logic [7:0]  END_MARKER_RESET   = 8'd10;
    localparam logic [15:0] BYTE_TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [2:0] status_code;
        logic [5:0] frame_total;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  head_marker;
        logic [7:0]  end_marker;
        logic [15:0] byte_timeout_ticks;
    } cfg_t;

endpackage

// File: hdl/frp_in_stage.sv
module frp_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  frp_pkg::in_item_t s_item,
    input  logic             take,
    output logic             item_valid,
    output frp_pkg::in_item_t item
);
    import frp_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // The register may refill in the same cycle that its item moves on.
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: hdl/frp_core.sv
module frp_core #(
    parameter int MAX_FRAME = frp_pkg::MAX_FRAME_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  frp_pkg::in_item_t item,
    input  frp_pkg::cfg_t     cfg,
    output logic              res_valid,
    output frp_pkg::out_item_t res
);
    import frp_pkg::*;

    localparam logic [9:0] MAX_TOTAL = 10'(MAX_FRAME);

    phase_t      phase_reg, phase_next;
    logic        first_ok_reg, first_ok_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] timer_reg, timer_next;

    logic [15:0] timer_inc;
    logic [7:0]  count_inc;
    logic        timed_out;
    logic        too_long;
    logic        short_len;
    logic        body_more;
    logic        active;

    assign timer_inc = timer_reg + 16'd1;
    assign count_inc = count_reg + 8'd1;
    assign timed_out = timer_inc >= cfg.byte_timeout_ticks;
    assign too_long  = ({2'b00, item.rx_byte} + 10'd2) > MAX_TOTAL;
    assign short_len = item.rx_byte < 8'd2;
    assign body_more = count_inc < length_reg;
    // A byte or tick only matters while a frame is armed.
    assign active    = (phase_reg != PH_IDLE)
                       && (item.req_type == REQ_BYTE || item.req_type == REQ_TICK);

    always_comb begin
        phase_next    = phase_reg;
        first_ok_next = first_ok_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        timer_next    = timer_reg;
        if (fire) begin
            priority if (item.req_type == REQ_ARM) begin
                phase_next    = PH_HEAD;
                first_ok_next = 1'b0;
                length_next   = 8'd0;
                count_next    = 8'd0;
                timer_next    = 16'd0;
            end else if (active && item.req_type == REQ_TICK) begin
                timer_next = timer_inc;
                if (timed_out) begin
                    phase_next = PH_IDLE;
                end
            end else if (active) begin
                timer_next = 16'd0;
                unique case (phase_reg)
                    PH_HEAD: begin
                        first_ok_next = item.rx_byte == cfg.head_marker;
                        phase_next    = PH_LEN;
                    end
                    PH_LEN: begin
                        if (!first_ok_reg || short_len || too_long) begin
                            phase_next = PH_IDLE;
                        end else begin
                            length_next = item.rx_byte;
                            count_next  = 8'd0;
                            phase_next  = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        count_next = count_inc;
                        if (!body_more) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end else begin
                phase_next = phase_reg;
            end
        end
    end

    always_comb begin
        res_valid        = 1'b0;
        res.is_status    = 1'b1;
        res.payload_byte = 8'd0;
        res.status_code  = ST_OK;
        res.frame_total  = 6'd0;
        res.last         = 1'b1;
        if (fire && active) begin
            if (item.req_type == REQ_TICK) begin
                res_valid       = timed_out;
                res.status_code = (phase_reg == PH_BODY) ? ST_BODY_TIMEOUT : ST_HDR_TIMEOUT;
            end else begin
                unique case (phase_reg)
                    PH_LEN: begin
                        res_valid = !first_ok_reg || short_len || too_long;
                        priority if (!first_ok_reg) begin
                            res.status_code = ST_BAD_HEAD;
                        end else if (short_len) begin
                            res.status_code = ST_SHORT;
                        end else begin
                            res.status_code = ST_TOO_LONG;
                        end
                    end
                    PH_BODY: begin
                        res_valid = 1'b1;
                        if (body_more) begin
                            res.is_status    = 1'b0;
                            res.payload_byte = item.rx_byte;
                            res.last         = 1'b0;
                        end else if (item.rx_byte == cfg.end_marker) begin
                            res.frame_total = length_reg[5:0] + 6'd2;
                        end else begin
                            res.status_code = ST_BAD_END;
                        end
                    end
                    default: begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            first_ok_reg <= 1'b0;
            length_reg   <= 8'd0;
            count_reg    <= 8'd0;
            timer_reg    <= 16'd0;
        end else begin
            phase_reg    <= phase_next;
            first_ok_reg <= first_ok_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            timer_reg    <= timer_next;
        end
    end

endmodule

// File: hdl/frp_out_stage.sv
module frp_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  frp_pkg::out_item_t res,
    output logic               can_load,
    output logic               m_valid,
    input  logic               m_ready,
    output frp_pkg::out_item_t m_item
);
    import frp_pkg::*;

    logic      valid_reg;
    out_item_t item_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= res;
        end
    end

endmodule

// File: hdl/framed_packet_receiver.sv
// Receives one length-prefixed frame per arm item: a head byte, a length
// byte L, then L body bytes whose last one must equal the end marker. Body
// bytes before the last come out as payload items, and each frame closes
// with one status item (ok with total L+2, or an error code) unless a new
// arm cuts it short. Tick items drive a per-byte timeout that restarts on
// arm and on every byte. Each item passes an input register, the compare and
// counter logic, and an output register, so one item is taken per clock
// while the output register can load; any result waits in the output
// register, offered on m_valid, until m_ready is high.
module framed_packet_receiver #(
    parameter int MAX_FRAME = frp_pkg::MAX_FRAME_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  frp_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output frp_pkg::out_item_t m_item,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);
    import frp_pkg::*;

    cfg_t      cfg_reg;
    logic      item_valid;
    in_item_t  item;
    logic      can_load;
    logic      fire;
    logic      res_valid;
    out_item_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.head_marker        <= HEAD_MARKER_RESET;
            cfg_reg.end_marker         <= END_MARKER_RESET;
            cfg_reg.byte_timeout_ticks <= BYTE_TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HEAD_MARKER:  cfg_reg.head_marker        <= cfg_wdata[7:0];
                CFG_END_MARKER:   cfg_reg.end_marker         <= cfg_wdata[7:0];
                CFG_BYTE_TIMEOUT: cfg_reg.byte_timeout_ticks <= cfg_wdata;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign fire = item_valid && can_load;

    frp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    frp_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    frp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
